FILE: rtl/plti_pkg.sv
package plti_pkg;

  localparam int MAX_KNOTS = 32;
  localparam int MAX_COMPS = 8;
  localparam int KNOT_W = $clog2(MAX_KNOTS);
  localparam int COMP_W = $clog2(MAX_COMPS);
  localparam int VADDR_W = KNOT_W + COMP_W;
  localparam int POS_W = 16;
  localparam int VAL_W = 32;
  localparam int OUT_W = 40;
  localparam int NUM_W = VAL_W + POS_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int KCFG_W = 6;
  localparam int MCFG_W = 4;
  localparam int CFG_DATA_W = 6;

  localparam logic [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

  // request commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_VALUE = 2'd1;
  localparam logic [1:0] CMD_DERIV = 2'd2;

  // configuration register indexes
  localparam logic CFG_KNOTS = 1'b0;
  localparam logic CFG_COMPS = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_LO, S_RD_HI, S_CHECK, S_SCAN_RD, S_SCAN_CHK, S_SEG_H, S_SEG_L,
    S_SEG_CAP, S_VAL_RDL, S_VAL_RDH, S_VAL_CAP, S_MUL_L, S_MUL_H, S_SUM, S_DIV,
    S_STORE, S_EMIT, S_ERR
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_RD_LO, OP_RD_HI, OP_CHECK, OP_SCAN_RD, OP_SCAN_CHK, OP_SEG_H,
    OP_SEG_L, OP_SEG_CAP, OP_VAL_RDL, OP_VAL_RDH, OP_VAL_CAP, OP_MUL_L, OP_MUL_H,
    OP_SUM, OP_DIV, OP_STORE, OP_EMIT, OP_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } ctl_t;

  typedef struct packed {
    logic out_of_range;
    logic eq_bound;
    logic scan_more;
    logic exact;
    logic div_done;
    logic pass_one;
    logic last_comp;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/plti_ctrl.sv
module plti_ctrl import plti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  input  sts_t       sts,
  output logic       in_ready,
  output ctl_t       ctl
);

  state_t state_r, state_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_command == CMD_VALUE || in_command == CMD_DERIV)) begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO:   state_nxt = S_RD_HI;
      S_RD_HI:   state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (sts.out_of_range) begin
          state_nxt = S_ERR;
        end else if (sts.eq_bound) begin
          state_nxt = S_SEG_H;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = sts.scan_more ? S_SCAN_RD : S_SEG_H;
      S_SEG_H:    state_nxt = S_SEG_L;
      S_SEG_L:    state_nxt = S_SEG_CAP;
      S_SEG_CAP:  state_nxt = S_VAL_RDL;
      S_VAL_RDL:  state_nxt = S_VAL_RDH;
      S_VAL_RDH:  state_nxt = S_VAL_CAP;
      S_VAL_CAP:  state_nxt = sts.exact ? S_EMIT : S_MUL_L;
      S_MUL_L:    state_nxt = S_MUL_H;
      S_MUL_H:    state_nxt = S_SUM;
      S_SUM:      state_nxt = S_DIV;
      S_DIV:      state_nxt = sts.div_done ? S_STORE : S_DIV;
      S_STORE:    state_nxt = sts.pass_one ? S_EMIT : S_MUL_L;
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_comp ? S_IDLE : S_VAL_RDL;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // drive datapath commands
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    ctl.accept = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_IDLE:     ctl.op = OP_IDLE;
      S_RD_LO:    ctl.op = OP_RD_LO;
      S_RD_HI:    ctl.op = OP_RD_HI;
      S_CHECK:    ctl.op = OP_CHECK;
      S_SCAN_RD:  ctl.op = OP_SCAN_RD;
      S_SCAN_CHK: ctl.op = OP_SCAN_CHK;
      S_SEG_H:    ctl.op = OP_SEG_H;
      S_SEG_L:    ctl.op = OP_SEG_L;
      S_SEG_CAP:  ctl.op = OP_SEG_CAP;
      S_VAL_RDL:  ctl.op = OP_VAL_RDL;
      S_VAL_RDH:  ctl.op = OP_VAL_RDH;
      S_VAL_CAP:  ctl.op = OP_VAL_CAP;
      S_MUL_L:    ctl.op = OP_MUL_L;
      S_MUL_H:    ctl.op = OP_MUL_H;
      S_SUM:      ctl.op = OP_SUM;
      S_DIV:      ctl.op = OP_DIV;
      S_STORE:    ctl.op = OP_STORE;
      S_EMIT:     ctl.op = OP_EMIT;
      S_ERR:      ctl.op = OP_ERR;
      default:    ctl.op = OP_IDLE;
    endcase
  end

endmodule

FILE: rtl/plti_datapath.sv
module plti_datapath import plti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [1:0]              in_command,
  input  logic [KNOT_W-1:0]       in_knot_index,
  input  logic [COMP_W-1:0]       in_component_index,
  input  logic [POS_W-1:0]        in_knot_position,
  input  logic [VAL_W-1:0]        in_integral_value,
  input  logic [VAL_W-1:0]        in_sigma_value,
  input  logic [POS_W-1:0]        in_query_position,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_integral_out,
  output logic signed [OUT_W-1:0] out_sigma_out,
  output logic [COMP_W-1:0]       out_component_out,
  output logic                    out_last,
  output logic                    out_out_of_range,
  input  ctl_t                    ctl,
  output sts_t                    sts
);

  // table storage
  logic [POS_W-1:0] pos_mem [MAX_KNOTS];
  logic [VAL_W-1:0] int_mem [MAX_KNOTS*MAX_COMPS];
  logic [VAL_W-1:0] sig_mem [MAX_KNOTS*MAX_COMPS];

  logic [KCFG_W-1:0]  knots_r;
  logic [MCFG_W-1:0]  comps_r;
  logic [KNOT_W-1:0]  nm1;
  logic [COMP_W-1:0]  mm1;

  logic [POS_W-1:0]   pos_rd_r, q_r, lo_r, ph_r, wl_r, wh_r, dabs_r;
  logic               deriv_r, exact_r, dneg_r, pass_r, neg_r;
  logic [VAL_W-1:0]   int_rd_r, sig_rd_r, li_r, ls_r, hi_r, hs_r;
  logic [KNOT_W-1:0]  idx_r, pos_raddr;
  logic [COMP_W-1:0]  comp_r;
  logic [VADDR_W-1:0] vaddr;
  logic [VAL_W:0]     diff_r;
  logic [NUM_W-1:0]   prod_r, acc_r, dq_r;
  logic [POS_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [OUT_W-1:0]   res_i_r, res_s_r, res;
  logic               out_valid_r;

  logic [VAL_W-1:0]   sel_l, sel_h;
  logic [POS_W:0]     den, trial;
  logic               ge, cond;
  logic [OUT_W-1:0]   qv;
  logic               big;

  // effective last knot and component indexes
  always_comb begin
    priority if (knots_r < KCFG_W'(2)) begin
      nm1 = KNOT_W'(1);
    end else if (knots_r > KCFG_W'(MAX_KNOTS)) begin
      nm1 = KNOT_W'(MAX_KNOTS - 1);
    end else begin
      nm1 = KNOT_W'(knots_r - KCFG_W'(1));
    end
    priority if (comps_r < MCFG_W'(1)) begin
      mm1 = '0;
    end else if (comps_r > MCFG_W'(MAX_COMPS)) begin
      mm1 = COMP_W'(MAX_COMPS - 1);
    end else begin
      mm1 = COMP_W'(comps_r - MCFG_W'(1));
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knots_r <= KCFG_W'(2);
      comps_r <= MCFG_W'(MAX_COMPS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KNOTS: knots_r <= cfg_wdata[KCFG_W-1:0];
        CFG_COMPS: comps_r <= cfg_wdata[MCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read addresses
  always_comb begin
    unique case (ctl.op)
      OP_RD_HI:   pos_raddr = nm1;
      OP_SCAN_RD: pos_raddr = idx_r;
      OP_SEG_H:   pos_raddr = idx_r;
      OP_SEG_L:   pos_raddr = idx_r - KNOT_W'(1);
      default:    pos_raddr = '0;
    endcase
    if (ctl.op == OP_VAL_RDL) begin
      vaddr = {idx_r - KNOT_W'(1), comp_r};
    end else begin
      vaddr = {idx_r, comp_r};
    end
  end

  // table write on request accept, registered reads
  always_ff @(posedge clk) begin
    if (ctl.accept && in_command == CMD_WRITE) begin
      pos_mem[in_knot_index] <= in_knot_position;
      int_mem[{in_knot_index, in_component_index}] <= in_integral_value;
      sig_mem[{in_knot_index, in_component_index}] <= in_sigma_value;
    end
    pos_rd_r <= pos_mem[pos_raddr];
    int_rd_r <= int_mem[vaddr];
    sig_rd_r <= sig_mem[vaddr];
  end

  assign den   = {1'b0, ph_r} - {1'b0, pos_rd_r};
  assign sel_l = pass_r ? ls_r : li_r;
  assign sel_h = pass_r ? hs_r : hi_r;
  assign cond  = deriv_r ? (pos_rd_r <= q_r) : (pos_rd_r < q_r);
  assign trial = {rem_r, dq_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, dabs_r};
  assign qv    = dq_r[OUT_W-1:0];
  assign big   = |dq_r[NUM_W-1:OUT_W-1];

  // result of one pass
  always_comb begin
    if (!deriv_r) begin
      res = OUT_W'(dq_r[VAL_W-1:0]);
    end else if (dabs_r == '0) begin
      res = (diff_r == '0) ? '0 : (neg_r ? SAT_LO : SAT_HI);
    end else if (neg_r) begin
      res = big ? SAT_LO : (~qv + OUT_W'(1));
    end else begin
      res = big ? SAT_HI : qv;
    end
  end

  // query sequencing registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      q_r     <= in_query_position;
      deriv_r <= (in_command == CMD_DERIV);
    end
    unique case (ctl.op)
      OP_RD_HI: lo_r <= pos_rd_r;
      OP_CHECK: begin
        priority if (q_r == lo_r) begin
          idx_r <= deriv_r ? KNOT_W'(1) : '0;
        end else if (q_r == pos_rd_r) begin
          idx_r <= nm1;
        end else begin
          idx_r <= KNOT_W'(1);
        end
      end
      OP_SCAN_CHK: begin
        if (idx_r != nm1 && cond) begin
          idx_r <= idx_r + KNOT_W'(1);
        end
      end
      OP_SEG_L: ph_r <= pos_rd_r;
      OP_SEG_CAP: begin
        exact_r <= !deriv_r && (ph_r == q_r);
        wl_r    <= ph_r - q_r;
        wh_r    <= q_r - pos_rd_r;
        dneg_r  <= den[POS_W];
        dabs_r  <= den[POS_W] ? POS_W'(-den) : den[POS_W-1:0];
        comp_r  <= '0;
      end
      OP_VAL_RDH: begin
        li_r <= int_rd_r;
        ls_r <= sig_rd_r;
      end
      OP_VAL_CAP: begin
        hi_r   <= int_rd_r;
        hs_r   <= sig_rd_r;
        pass_r <= 1'b0;
      end
      OP_MUL_L: begin
        prod_r <= sel_l * wl_r;
        diff_r <= dneg_r ? ({1'b0, sel_l} - {1'b0, sel_h})
                         : ({1'b0, sel_h} - {1'b0, sel_l});
      end
      OP_MUL_H: begin
        prod_r <= sel_h * wh_r;
        acc_r  <= prod_r + NUM_W'(dabs_r >> 1);
        neg_r  <= diff_r[VAL_W];
        diff_r <= diff_r[VAL_W] ? -diff_r : diff_r;
      end
      OP_SUM: begin
        dq_r  <= deriv_r ? (NUM_W'({diff_r, 12'd0}) + NUM_W'(dabs_r >> 1))
                         : (acc_r + prod_r);
        rem_r <= '0;
        cnt_r <= CNT_W'(DIV_STEPS);
      end
      OP_DIV: begin
        if (cnt_r != '0) begin
          rem_r <= ge ? POS_W'(trial - {1'b0, dabs_r}) : trial[POS_W-1:0];
          dq_r  <= {dq_r[NUM_W-2:0], ge};
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      OP_STORE: begin
        if (pass_r) begin
          res_s_r <= res;
        end else begin
          res_i_r <= res;
          pass_r  <= 1'b1;
        end
      end
      OP_EMIT: begin
        if (sts.out_free) begin
          comp_r <= comp_r + COMP_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.op == OP_EMIT || ctl.op == OP_ERR) && sts.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && sts.out_free) begin
      out_integral_out  <= exact_r ? OUT_W'(hi_r) : res_i_r;
      out_sigma_out     <= exact_r ? OUT_W'(hs_r) : res_s_r;
      out_component_out <= comp_r;
      out_last          <= (comp_r == mm1);
      out_out_of_range  <= 1'b0;
    end else if (ctl.op == OP_ERR && sts.out_free) begin
      out_integral_out  <= '0;
      out_sigma_out     <= '0;
      out_component_out <= '0;
      out_last          <= 1'b1;
      out_out_of_range  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // status to controller
  always_comb begin
    sts.out_of_range = (q_r < lo_r) || (q_r > pos_rd_r);
    sts.eq_bound     = (q_r == lo_r) || (q_r == pos_rd_r);
    sts.scan_more    = (idx_r != nm1) && cond;
    sts.exact        = exact_r;
    sts.div_done     = (cnt_r == '0);
    sts.pass_one     = pass_r;
    sts.last_comp    = (comp_r == mm1);
    sts.out_free     = !out_valid_r || out_ready;
  end

endmodule

FILE: rtl/piecewise_linear_table_interpolator_core.sv
// A write request is taken in the idle state. A query reads the bounds and, if in range,
// scans up to knots-1 knots, reads the segment, then per component gives the stored values
// on an exact knot or else two 48-step restoring divisions that share one divider.
// One request at a time; a finished result waits in the output register while the next
// request is taken. Synchronous active-low reset clears the controller, the output valid and
// the configuration (2 knots, 8 components); the knot table is undefined until written.
module piecewise_linear_table_interpolator_core import plti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic [KNOT_W-1:0]       in_knot_index,
  input  logic [COMP_W-1:0]       in_component_index,
  input  logic [POS_W-1:0]        in_knot_position,
  input  logic [VAL_W-1:0]        in_integral_value,
  input  logic [VAL_W-1:0]        in_sigma_value,
  input  logic [POS_W-1:0]        in_query_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_integral_out,
  output logic signed [OUT_W-1:0] out_sigma_out,
  output logic [COMP_W-1:0]       out_component_out,
  output logic                    out_last,
  output logic                    out_out_of_range
);

  ctl_t ctl;
  sts_t sts;

  plti_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .in_ready   (in_ready),
    .ctl        (ctl)
  );

  plti_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_knot_index      (in_knot_index),
    .in_component_index (in_component_index),
    .in_knot_position   (in_knot_position),
    .in_integral_value  (in_integral_value),
    .in_sigma_value     (in_sigma_value),
    .in_query_position  (in_query_position),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_integral_out   (out_integral_out),
    .out_sigma_out      (out_sigma_out),
    .out_component_out  (out_component_out),
    .out_last           (out_last),
    .out_out_of_range   (out_out_of_range),
    .ctl                (ctl),
    .sts                (sts)
  );

endmodule
